// File: src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// shared constants and command/status types for the rational unit
// ----------------------------------------------------------------------------
package rau_pkg;
  localparam int MAG_W = 64;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  typedef struct packed {
    logic load;      // capture operands
    logic mul;       // run multiply step
    logic form;      // form unreduced numerator and denominator
    logic gcd_init;  // start euclid
    logic div_init;  // start a divide
    logic div_step;  // one restoring divide bit
    logic gcd_next;  // u <= v, v <= remainder
    logic red_num;   // start dividing numerator by gcd
    logic red_den;   // start dividing denominator by gcd
    logic save_num;  // store reduced numerator
    logic finish;    // build result
  } rau_cmd_t;

  typedef struct packed {
    logic special;   // undefined or zero numerator, result ready after form
    logic v_zero;    // euclid done
    logic div_done;  // divide finished
  } rau_sts_t;
endpackage

// File: src/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// operand registers, shared 32x32 multiplier, bit-serial divider and result
// ----------------------------------------------------------------------------
module rau_datapath import rau_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic [1:0]         mode,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic               a_undef,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  input  logic               b_undef,
  input  rau_cmd_t           cmd,
  output rau_sts_t           sts,
  output logic signed [31:0] res_num,
  output logic [30:0]        res_den,
  output logic               res_undef,
  output logic               overflow
);
  logic [1:0]  md;
  logic        undef;
  logic [31:0] anm, adm, bnm, bdm;
  logic        an, ad, bn, bd;
  logic [1:0]  mcnt;
  logic [MAG_W-1:0] p0, p1, p2;
  logic [MAG_W-1:0] nm, dm;
  logic        nneg, dneg;
  logic [MAG_W-1:0] u, v;
  logic [MAG_W-1:0] dq, dr, dd;
  logic [6:0]  dcnt;
  logic [MAG_W-1:0] rnum;

  logic [31:0] ma, mb;
  logic [MAG_W-1:0] prod;
  logic [MAG_W:0]   trial;
  logic [MAG_W-1:0] rsh;
  logic        s1, s2;
  logic [MAG_W-1:0] sum;
  logic        sneg;
  logic [MAG_W:0] lim;
  logic        neg, ovf;

  function automatic logic [31:0] mag(input logic [31:0] x);
    mag = x[31] ? (32'd0 - x) : x;
  endfunction

  always_comb begin
    case (mcnt)
      2'd0: begin ma = anm; mb = (md == MODE_MUL) ? bnm : bdm; end
      2'd1: begin ma = bnm; mb = adm; end
      default: begin ma = adm; mb = (md == MODE_DIV) ? bnm : bdm; end
    endcase
  end
  assign prod = {32'd0, ma} * {32'd0, mb};

  always_comb begin
    s1 = (md == MODE_MUL) ? (an ^ bn) : (an ^ bd);
    s2 = (bn ^ ad) ^ (md == MODE_SUB);
    if (s1 == s2) begin
      sum = p0 + p1; sneg = s1;
    end else if (p0 >= p1) begin
      sum = p0 - p1; sneg = s1;
    end else begin
      sum = p1 - p0; sneg = s2;
    end
  end

  assign rsh   = {dr[MAG_W-2:0], dq[MAG_W-1]};
  assign trial = {1'b0, rsh} - {1'b0, dd};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      md    <= mode;
      undef <= a_undef | b_undef;
      anm <= mag(a_num); an <= a_num[31];
      adm <= mag(a_den); ad <= a_den[31];
      bnm <= mag(b_num); bn <= b_num[31];
      bdm <= mag(b_den); bd <= b_den[31];
      mcnt <= 2'd0;
    end
    if (cmd.mul) begin
      case (mcnt)
        2'd0:    p0 <= prod;
        2'd1:    p1 <= prod;
        default: p2 <= prod;
      endcase
      mcnt <= mcnt + 2'd1;
    end
    if (cmd.form) begin
      if (md == MODE_ADD || md == MODE_SUB) begin
        nm <= sum; nneg <= sneg;
      end else begin
        nm <= p0; nneg <= s1;
      end
      dm   <= p2;
      dneg <= (md == MODE_DIV) ? (ad ^ bn) : (ad ^ bd);
    end
    if (cmd.gcd_init) begin
      u <= nm; v <= dm;
    end
    if (cmd.div_init) begin
      dq <= u; dr <= '0; dd <= v; dcnt <= 7'd0;
    end
    if (cmd.red_num) begin
      dq <= nm; dr <= '0; dd <= u; dcnt <= 7'd0;
    end
    if (cmd.red_den) begin
      dq <= dm; dr <= '0; dd <= u; dcnt <= 7'd0;
    end
    if (cmd.div_step) begin
      if (!trial[MAG_W]) begin
        dr <= trial[MAG_W-1:0];
        dq <= {dq[MAG_W-2:0], 1'b1};
      end else begin
        dr <= rsh;
        dq <= {dq[MAG_W-2:0], 1'b0};
      end
      dcnt <= dcnt + 7'd1;
    end
    if (cmd.gcd_next) begin
      u <= v; v <= dr;
    end
    if (cmd.save_num) rnum <= dq;
    if (cmd.finish) begin
      if (undef || dm == '0) begin
        res_num <= '0; res_den <= '0; res_undef <= 1'b1; overflow <= 1'b0;
      end else if (nm == '0) begin
        res_num <= '0; res_den <= 31'd1; res_undef <= 1'b0; overflow <= 1'b0;
      end else begin
        res_num   <= neg ? (32'd0 - rnum[31:0]) : rnum[31:0];
        res_den   <= dq[30:0];
        res_undef <= 1'b0;
        overflow  <= ovf;
      end
    end
  end

  assign neg = nneg ^ dneg;
  assign lim = {{MAG_W{1'b0}}, 1'b1} << (WIDTH - 1);
  assign ovf = (neg ? ({1'b0, rnum} > lim) : ({1'b0, rnum} >= lim)) || ({1'b0, dq} >= lim);

  assign sts.special  = undef || dm == '0 || nm == '0;
  assign sts.v_zero   = (v == '0);
  assign sts.div_done = (dcnt == 7'(MAG_W));
endmodule

// File: src/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer: multiply, euclid, reduce, deliver
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  rau_sts_t sts,
  output rau_cmd_t cmd
);
  localparam logic [3:0] S_IDLE = 4'd0, S_M0 = 4'd1, S_M1 = 4'd2, S_M2 = 4'd3,
    S_FORM = 4'd4, S_CHK = 4'd5, S_GTEST = 4'd6, S_GDIV = 4'd7,
    S_RN = 4'd8, S_RD = 4'd9, S_FIN = 4'd10;

  logic [3:0] state, state_next;
  logic       busy;

  assign busy     = state != S_IDLE;
  assign in_stall = busy || (out_valid && out_stall);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_valid && !in_stall) begin
        cmd.load = 1'b1; state_next = S_M0;
      end
      S_M0: begin cmd.mul = 1'b1; state_next = S_M1; end
      S_M1: begin cmd.mul = 1'b1; state_next = S_M2; end
      S_M2: begin cmd.mul = 1'b1; state_next = S_FORM; end
      S_FORM: begin cmd.form = 1'b1; state_next = S_CHK; end
      S_CHK: begin
        if (sts.special) state_next = S_FIN;
        else begin cmd.gcd_init = 1'b1; state_next = S_GTEST; end
      end
      S_GTEST: begin
        if (sts.v_zero) begin cmd.red_num = 1'b1; state_next = S_RN; end
        else begin cmd.div_init = 1'b1; state_next = S_GDIV; end
      end
      S_GDIV: begin
        if (sts.div_done) begin cmd.gcd_next = 1'b1; state_next = S_GTEST; end
        else cmd.div_step = 1'b1;
      end
      S_RN: begin
        if (sts.div_done) begin
          cmd.save_num = 1'b1; cmd.red_den = 1'b1; state_next = S_RD;
        end else cmd.div_step = 1'b1;
      end
      S_RD: begin
        if (sts.div_done) state_next = S_FIN;
        else cmd.div_step = 1'b1;
      end
      S_FIN: if (!(out_valid && out_stall)) begin
        cmd.finish = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
endmodule

// File: src/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit
// exact rational add/sub/mul/div with euclidean gcd reduction
// ----------------------------------------------------------------------------
// undefined or zero results skip euclid and reduction; otherwise one serial
//   divide per euclid remainder, then the two reducing divides
// throughput: one request at a time, in_stall held while the sequencer is busy
// reset: synchronous rst clears the sequencer and the output valid
module rational_arith_unit import rau_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic               a_undef,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  input  logic               b_undef,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] res_num,
  output logic [30:0]        res_den,
  output logic               res_undef,
  output logic               overflow
);
  // command and status between sequencer and datapath
  rau_cmd_t cmd;
  rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  // output register holds the result while the request waits downstream
  rau_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk, .mode, .a_num, .a_den, .a_undef, .b_num, .b_den, .b_undef,
    .cmd, .sts, .res_num, .res_den, .res_undef, .overflow
  );
endmodule

// File: tb/sv/rational_arith_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arith_unit_tb
// drives signed rational operand pairs through all four operations, predicts
// the reduced result with exact 64-bit sign-magnitude math and checks every
// result in order against the block's output
// ----------------------------------------------------------------------------
module rational_arith_unit_tb import rau_pkg::*;;

  localparam int WIDTH = 32;

  // one request as the block sees it
  typedef struct {
    logic [1:0]         mode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic               a_undef;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
    logic               b_undef;
  } rat_req_t;

  // one reduced result
  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               undef;
    logic               ovf;
  } rat_res_t;

  // split a 32-bit two's complement field into magnitude and sign
  function automatic logic [63:0] field_mag(input logic [31:0] v, output logic neg);
    neg = v[31];
    return neg ? (64'd1 << 32) - {32'd0, v} : {32'd0, v};
  endfunction

  // sign-magnitude sum, magnitudes at most 2^62 so no carry out
  function automatic logic [63:0] signed_mag_sum(input logic [63:0] xm, input logic xn,
                                                 input logic [63:0] ym, input logic yn,
                                                 output logic rn);
    if (xn == yn) begin
      rn = xn;
      return xm + ym;
    end
    if (xm >= ym) begin
      rn = xn;
      return xm - ym;
    end
    rn = yn;
    return ym - xm;
  endfunction

  function automatic logic [63:0] euclid_gcd(input logic [63:0] u, input logic [63:0] v);
    logic [63:0] r;
    while (v != 0) begin
      r = u % v;
      u = v;
      v = r;
    end
    return u;
  endfunction

  // expected reduced rational for one request
  function automatic rat_res_t reduce_rational(input rat_req_t q);
    rat_res_t    r;
    logic        an, ad, bn, bd, nneg, dneg, neg, ovf;
    logic [63:0] anm, adm, bnm, bdm, nm, dm, g, lim;
    r = '{num: '0, den: '0, undef: 1'b0, ovf: 1'b0};
    anm = field_mag(q.a_num, an);
    adm = field_mag(q.a_den, ad);
    bnm = field_mag(q.b_num, bn);
    bdm = field_mag(q.b_den, bd);
    if (q.a_undef || q.b_undef) begin
      r.undef = 1'b1;
      return r;
    end
    case (q.mode)
      MODE_ADD, MODE_SUB: begin
        nm = signed_mag_sum(anm * bdm, an ^ bd, bnm * adm,
                            (bn ^ ad) ^ (q.mode == MODE_SUB), nneg);
        dm = adm * bdm;
        dneg = ad ^ bd;
      end
      MODE_MUL: begin
        nm = anm * bnm;
        nneg = an ^ bn;
        dm = adm * bdm;
        dneg = ad ^ bd;
      end
      default: begin
        nm = anm * bdm;
        nneg = an ^ bd;
        dm = adm * bnm;
        dneg = ad ^ bn;
      end
    endcase
    if (dm == 0) begin
      r.undef = 1'b1;
      return r;
    end
    if (nm == 0) begin
      r.den = 31'd1;
      return r;
    end
    g = euclid_gcd(nm, dm);
    nm = nm / g;
    dm = dm / g;
    lim = 64'd1 << (WIDTH - 1);
    neg = nneg ^ dneg;
    ovf = (neg ? (nm > lim) : (nm >= lim)) || (dm >= lim);
    nm = neg ? (64'd0 - nm) : nm;
    r.num = nm[31:0];
    r.den = dm[30:0];
    r.ovf = ovf;
    return r;
  endfunction

  // in-order store of predicted results
  class rational_scoreboard;
    rat_res_t pending[$];
    int       errors;

    function void note_request(input rat_req_t q);
      pending.push_back(reduce_rational(q));
    endfunction

    function void check_result(input rat_res_t got);
      rat_res_t want;
      if (pending.size() == 0) begin
        report(got, got, 1'b1);
        return;
      end
      want = pending.pop_front();
      if (want.num !== got.num || want.den !== got.den ||
          want.undef !== got.undef || want.ovf !== got.ovf)
        report(want, got, 1'b0);
    endfunction

    function void report(input rat_res_t want, input rat_res_t got, input logic stray);
      errors++;
      if (errors > 10) return;
      if (stray)
        $display("unexpected result num=%0d den=%0d undef=%0b ovf=%0b",
                 got.num, got.den, got.undef, got.ovf);
      else
        $display("mismatch exp num=%0d den=%0d undef=%0b ovf=%0b got num=%0d den=%0d undef=%0b ovf=%0b",
                 want.num, want.den, want.undef, want.ovf,
                 got.num, got.den, got.undef, got.ovf);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         mode;
  logic signed [31:0] a_num;
  logic signed [31:0] a_den;
  logic               a_undef;
  logic signed [31:0] b_num;
  logic signed [31:0] b_den;
  logic               b_undef;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] res_num;
  logic [30:0]        res_den;
  logic               res_undef;
  logic               overflow;

  rational_scoreboard board = new();

  // receiver hold-off request from the stimulus side, cycles counted below
  int  hold_cycles = 0;
  bit  hold_busy = 0;

  rational_arith_unit #(.WIDTH(WIDTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .a_num(a_num), .a_den(a_den), .a_undef(a_undef),
    .b_num(b_num), .b_den(b_den), .b_undef(b_undef),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_num(res_num), .res_den(res_den), .res_undef(res_undef),
    .overflow(overflow)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result side: stall pattern changes from phase to phase, long hold-off
  // when the stimulus asks for one
  initial begin
    int phase_left;
    int stall_pct;
    out_stall = 1'b1;
    phase_left = 0;
    stall_pct = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        hold_busy <= 1'b1;
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        hold_busy <= 1'b0;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 80);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 70;
          default: stall_pct = 95;
        endcase
      end
      phase_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      @(posedge clk);
    end
  end

  // results are sampled at the edge, outputs are stable then
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result('{num: res_num, den: res_den, undef: res_undef, ovf: overflow});
  end

  // present one request and hold it until accepted
  task automatic send_request(input rat_req_t q);
    mode <= q.mode;
    a_num <= q.a_num;
    a_den <= q.a_den;
    a_undef <= q.a_undef;
    b_num <= q.b_num;
    b_den <= q.b_den;
    b_undef <= q.b_undef;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(q);
  endtask

  task automatic idle_gap(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // mostly small operands so reductions are common, with full-range and
  // edge values mixed in
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3, 4: return $urandom();
      5: return 32'(-$signed({1'b0, $urandom_range(1, 1000)}));
      6: return $urandom_range(1, 1 << 16) * $urandom_range(1, 12);
      default: return 32'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  function automatic rat_req_t random_request();
    rat_req_t q;
    q.mode = 2'($urandom_range(0, 3));
    q.a_num = pick_value();
    q.b_num = pick_value();
    q.a_den = pick_value();
    q.b_den = pick_value();
    // zero denominators are kept but made rarer
    if (q.a_den == 0 && $urandom_range(0, 3) != 0) q.a_den = 32'd1;
    if (q.b_den == 0 && $urandom_range(0, 3) != 0) q.b_den = 32'd1;
    q.a_undef = ($urandom_range(0, 19) == 0);
    q.b_undef = ($urandom_range(0, 19) == 0);
    return q;
  endfunction

  function automatic rat_req_t make_request(input logic [1:0] m, input logic [31:0] an,
                                            input logic [31:0] ad, input logic [31:0] bn,
                                            input logic [31:0] bd, input logic au,
                                            input logic bu);
    rat_req_t q;
    q = '{mode: m, a_num: an, a_den: ad, a_undef: au, b_num: bn, b_den: bd, b_undef: bu};
    return q;
  endfunction

  initial begin
    rat_req_t directed[$];
    int burst;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_ADD;
    a_num = '0;
    a_den = '0;
    a_undef = 1'b0;
    b_num = '0;
    b_den = '0;
    b_undef = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every operation on plain values
    directed.push_back(make_request(MODE_ADD, 1, 2, 1, 3, 0, 0));
    directed.push_back(make_request(MODE_SUB, 1, 2, 1, 3, 0, 0));
    directed.push_back(make_request(MODE_MUL, -2, 3, 9, 4, 0, 0));
    directed.push_back(make_request(MODE_DIV, 3, -4, -9, 8, 0, 0));
    // undefined operands, both sides and both at once
    directed.push_back(make_request(MODE_ADD, 5, 7, 1, 1, 1, 0));
    directed.push_back(make_request(MODE_MUL, 5, 7, 1, 1, 0, 1));
    directed.push_back(make_request(MODE_DIV, 5, 7, 1, 1, 1, 1));
    // zero denominators and divide by zero numerator
    directed.push_back(make_request(MODE_ADD, 1, 0, 1, 3, 0, 0));
    directed.push_back(make_request(MODE_SUB, 1, 3, 1, 0, 0, 0));
    directed.push_back(make_request(MODE_DIV, 1, 3, 0, 5, 0, 0));
    // zero numerator reduces to 0/1
    directed.push_back(make_request(MODE_SUB, 2, 3, 2, 3, 0, 0));
    directed.push_back(make_request(MODE_MUL, 0, -5, 7, 3, 0, 0));
    // sign from negative denominators
    directed.push_back(make_request(MODE_ADD, -1, -2, 1, -2, 0, 0));
    // extremes: overflow on numerator and denominator, and 2^31 magnitudes
    directed.push_back(make_request(MODE_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1, 0, 0));
    directed.push_back(make_request(MODE_MUL, 32'h8000_0000, 1, 1, 1, 0, 0));
    directed.push_back(make_request(MODE_MUL, 32'h8000_0000, 1, -1, 1, 0, 0));
    directed.push_back(make_request(MODE_DIV, 1, 32'h8000_0000, 1, -1, 0, 0));
    directed.push_back(make_request(MODE_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1, 0, 0));
    directed.push_back(make_request(MODE_SUB, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    directed.push_back(make_request(MODE_MUL, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 0, 0));
    directed.push_back(make_request(MODE_DIV, -1, -1, -1, -1, 0, 0));
    foreach (directed[i]) send_request(directed[i]);
    in_valid <= 1'b0;

    // wait for the block to drain completely
    while (board.pending.size() != 0) @(posedge clk);

    for (int n = 0; n < 1030;) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n < 1030; k++, n++) begin
        send_request(random_request());
        if (n == 300) begin
          // receiver holds off long while requests keep coming
          hold_cycles = 3000;
        end
        if (n == 600) begin
          // sender pauses until every result is back
          in_valid <= 1'b0;
          while (board.pending.size() != 0) @(posedge clk);
        end
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(0, 300));
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0 || hold_busy) @(posedge clk);
    repeat (500) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // generous limit on simulated time: ~1050 requests even with the longest
  // euclid chains and stalls, with ample margin
  initial begin
    #300_000_000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
